>>> rtl/delta_list_event_scheduler_unit_assert.svh
// Assertion macros for the delta list event scheduler.
`ifndef DELTA_LIST_EVENT_SCHEDULER_UNIT_ASSERT_SVH
`define DELTA_LIST_EVENT_SCHEDULER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DLSE_ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dlse check failed");
`define DLSE_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("dlse forbidden condition");
`else
`define DLSE_ASSERT_HOLDS(label, clk, rst, prop)
`define DLSE_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

>>> rtl/dlse_pkg.sv
`default_nettype none
package dlse_pkg;
   localparam int SLOT_W = 6;
   localparam logic [31:0] IDLE_PERIOD_RESET = 32'h0000_4000;

   typedef logic [SLOT_W-1:0] slot_type;

   typedef struct packed {
      logic        valid;
      slot_type    id;
      logic [31:0] delta;
   } entry_type;

   typedef enum logic [1:0] {
      CMD_NONE   = 2'd0,
      CMD_DEL    = 2'd1,
      CMD_INS    = 2'd2,
      CMD_RELOAD = 2'd3
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      slot_type   pos;
      logic       add;
      entry_type  ent;
   } cmd_type;
endpackage
`default_nettype wire

>>> rtl/dlse_cell.sv
`default_nettype none
module dlse_cell import dlse_pkg::*; #(
   parameter int INDEX   = 0,
   parameter int IDLE_ID = 15
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cmd_type   cmd,
   input  wire entry_type left,
   input  wire entry_type right,
   output entry_type      entry
);
   entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.op)
         CMD_DEL: begin
            // close the gap: take the right neighbor, fold the removed delta in
            if (INDEX >= int'(cmd.pos)) begin
               entry_in = right;
               if (INDEX == int'(cmd.pos) && cmd.add) begin
                  entry_in.delta = right.delta + entry_ff.delta;
               end
            end
         end
         CMD_INS: begin
            if (INDEX == int'(cmd.pos)) begin
               entry_in = cmd.ent;
            end else if (INDEX > int'(cmd.pos)) begin
               entry_in = left;
               if (INDEX == int'(cmd.pos) + 1) begin
                  entry_in.delta = left.delta - cmd.ent.delta;
               end
            end
         end
         CMD_RELOAD: begin
            if (entry_ff.valid && entry_ff.id == cmd.ent.id) begin
               entry_in.delta = cmd.ent.delta;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= (INDEX == 0);
         entry_ff.id    <= SLOT_W'(IDLE_ID);
         entry_ff.delta <= IDLE_PERIOD_RESET;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;
endmodule
`default_nettype wire

>>> rtl/delta_list_event_scheduler_unit.sv
`default_nettype none
// Channel   Ports                          Handshake
// request   req_kind .. req_pending_cycles accepted when start high and busy low
// response  rsp_fired_valid .. cycle_count one cycle, marked by rsp_strobe
// config    csr_write_enable, csr_write_data written on any edge with enable high
//
// Busy states per beat: service SVC then RESP when not due, or SVC, SVCH, RESP on a pop;
// cancel LOOK, then POST only when the slot was linked, then RESP; ignored slot or unknown
// kind RESP alone; schedule LOOK, POST when the slot was already linked, WALK, FIX, RESP.
// The walk through the cell row, one entry a cycle, sets the schedule time.
// Synchronous reset leaves only the idle slot in the list; no clearing pass.
// The receiver cannot stall; busy stays high until the response cycle ends.
`include "delta_list_event_scheduler_unit_assert.svh"
module delta_list_event_scheduler_unit import dlse_pkg::*; #(
   parameter int EVENT_SLOTS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_kind,
   input  wire logic [3:0]         req_event_id,
   input  wire logic [30:0]        req_delay,
   input  wire logic [30:0]        req_pending_cycles,
   input  wire logic               csr_write_enable,
   input  wire logic [30:0]        csr_write_data,
   output logic                    rsp_strobe,
   output logic                    rsp_fired_valid,
   output logic [3:0]              rsp_fired_event,
   output logic [3:0]              rsp_head_event,
   output logic signed [31:0]      rsp_countdown,
   output logic signed [31:0]      rsp_duration,
   output logic                    rsp_more_due,
   output logic [31:0]             rsp_cycle_count
);
   localparam slot_type IDLE_SLOT = SLOT_W'(EVENT_SLOTS - 1);
   localparam int POS_W = $clog2(EVENT_SLOTS);
   localparam logic [1:0] KIND_SCHEDULE = 2'd0;
   localparam logic [1:0] KIND_CANCEL   = 2'd1;
   localparam logic [1:0] KIND_SERVICE  = 2'd2;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_LOOK = 8'b0000_0010,
      ST_POST = 8'b0000_0100,
      ST_WALK = 8'b0000_1000,
      ST_FIX  = 8'b0001_0000,
      ST_SVC  = 8'b0010_0000,
      ST_SVCH = 8'b0100_0000,
      ST_RESP = 8'b1000_0000
   } state_type;

   state_type   state_ff, state_in;
   logic [30:0] idle_period_ff;
   logic [1:0]  kind_ff, kind_in;
   slot_type    id_ff, id_in;
   logic [31:0] delay_ff, delay_in;
   logic [31:0] pending_ff, pending_in;
   logic        head_chg_ff, head_chg_in;
   slot_type    pos_ff, pos_in;
   logic [31:0] running_ff, running_in;
   logic [31:0] countdown_ff, countdown_in;
   logic [31:0] duration_ff, duration_in;
   logic [31:0] cycle_ff, cycle_in;
   logic        fired_ff, fired_in;
   slot_type    fired_ev_ff, fired_ev_in;

   entry_type cell_q [EVENT_SLOTS];
   cmd_type   cmd;
   entry_type walk_ent;
   entry_type reload_ent;
   logic [31:0] walk_sum;
   logic [31:0] new_delta;
   logic        match_found;
   slot_type    match_pos;
   logic        id_ok;

   genvar g;
   generate
      for (g = 0; g < EVENT_SLOTS; g++) begin : g_cell
         entry_type left_ent, right_ent;
         if (g == 0) begin : g_first
            assign left_ent = '0;
         end else begin : g_mid_l
            assign left_ent = cell_q[g-1];
         end
         if (g == EVENT_SLOTS - 1) begin : g_last
            assign right_ent = '0;
         end else begin : g_mid_r
            assign right_ent = cell_q[g+1];
         end
         dlse_cell #(.INDEX(g), .IDLE_ID(EVENT_SLOTS - 1)) u_cell (
            .clock(clock),
            .reset(reset),
            .cmd(cmd),
            .left(left_ent),
            .right(right_ent),
            .entry(cell_q[g])
         );
      end
   endgenerate

   always_comb begin
      match_found = 1'b0;
      match_pos   = '0;
      for (int i = EVENT_SLOTS - 1; i >= 0; i--) begin
         if (cell_q[i].valid && cell_q[i].id == id_ff) begin
            match_found = 1'b1;
            match_pos   = SLOT_W'(i);
         end
      end
   end

   assign id_ok      = 32'(req_event_id) < 32'(EVENT_SLOTS - 1);
   assign walk_ent   = cell_q[pos_ff[POS_W-1:0]];
   assign walk_sum   = running_ff + walk_ent.delta;
   assign new_delta  = delay_ff - running_ff;
   assign reload_ent = '{valid: 1'b1, id: IDLE_SLOT, delta: {1'b0, idle_period_ff}};

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      id_in        = id_ff;
      delay_in     = delay_ff;
      pending_in   = pending_ff;
      head_chg_in  = head_chg_ff;
      pos_in       = pos_ff;
      running_in   = running_ff;
      countdown_in = countdown_ff;
      duration_in  = duration_ff;
      cycle_in     = cycle_ff;
      fired_in     = fired_ff;
      fired_ev_in  = fired_ev_ff;
      cmd          = '{op: CMD_NONE, pos: '0, add: 1'b0, ent: reload_ent};
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in     = req_kind;
               id_in       = SLOT_W'(req_event_id);
               delay_in    = {1'b0, req_delay};
               pending_in  = {1'b0, req_pending_cycles};
               head_chg_in = 1'b0;
               fired_in    = 1'b0;
               fired_ev_in = '0;
               if (req_kind == KIND_SERVICE) begin
                  state_in = ST_SVC;
               end else if ((req_kind == KIND_SCHEDULE || req_kind == KIND_CANCEL) && id_ok) begin
                  state_in = ST_LOOK;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_LOOK: begin
            pos_in     = '0;
            running_in = 32'd0 - pending_ff;
            if (match_found) begin
               cmd.op      = CMD_DEL;
               cmd.pos     = match_pos;
               cmd.add     = 1'b1;
               head_chg_in = (match_pos == '0);
               state_in    = ST_POST;
            end else if (kind_ff == KIND_CANCEL) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_POST: begin
            // head regs see the folded delta before the idle reload lands
            if (head_chg_ff) begin
               duration_in  = cell_q[0].delta;
               countdown_in = cell_q[0].delta - pending_ff;
            end
            cmd.op   = CMD_RELOAD;
            state_in = (kind_ff == KIND_SCHEDULE) ? ST_WALK : ST_RESP;
         end
         ST_WALK: begin
            if (walk_ent.id == IDLE_SLOT || $signed(walk_sum) > $signed(delay_ff)) begin
               cmd.op  = CMD_INS;
               cmd.pos = pos_ff;
               cmd.ent = '{valid: 1'b1, id: id_ff, delta: new_delta};
               if (pos_ff == '0) begin
                  duration_in  = new_delta;
                  countdown_in = delay_ff;
               end
               state_in = ST_FIX;
            end else begin
               running_in = walk_sum;
               pos_in     = pos_ff + 1'b1;
            end
         end
         ST_FIX: begin
            cmd.op   = CMD_RELOAD;
            state_in = ST_RESP;
         end
         ST_SVC: begin
            if ($signed(countdown_ff) <= 0) begin
               fired_in    = 1'b1;
               fired_ev_in = cell_q[0].id;
               cycle_in    = cycle_ff + duration_ff;
               if (cell_q[0].id == IDLE_SLOT) begin
                  cmd.op = CMD_RELOAD;
               end else begin
                  cmd.op  = CMD_DEL;
                  cmd.pos = '0;
               end
               state_in = ST_SVCH;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_SVCH: begin
            duration_in  = cell_q[0].delta;
            countdown_in = countdown_ff + cell_q[0].delta;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         idle_period_ff <= IDLE_PERIOD_RESET[30:0];
         countdown_ff   <= '0;
         duration_ff    <= '0;
         cycle_ff       <= '0;
         fired_ff       <= 1'b0;
         fired_ev_ff    <= '0;
         head_chg_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         countdown_ff <= countdown_in;
         duration_ff  <= duration_in;
         cycle_ff     <= cycle_in;
         fired_ff     <= fired_in;
         fired_ev_ff  <= fired_ev_in;
         head_chg_ff  <= head_chg_in;
         if (csr_write_enable) begin
            idle_period_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      id_ff      <= id_in;
      delay_ff   <= delay_in;
      pending_ff <= pending_in;
      pos_ff     <= pos_in;
      running_ff <= running_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = (state_ff == ST_RESP);
   assign rsp_fired_valid = fired_ff;
   assign rsp_fired_event = 4'(fired_ev_ff);
   assign rsp_head_event  = 4'(cell_q[0].id);
   assign rsp_countdown   = $signed(countdown_ff);
   assign rsp_duration    = $signed(duration_ff);
   assign rsp_more_due    = ($signed(countdown_ff) <= 0);
   assign rsp_cycle_count = cycle_ff;

   `DLSE_ASSERT_HOLDS(a_resp_ends_beat, clock, reset, rsp_strobe |=> !busy)
   `DLSE_ASSERT_HOLDS(a_accept_busy, clock, reset, (start && !busy) |=> busy)
   `DLSE_ASSERT_NEVER(a_head_present, clock, reset, !cell_q[0].valid)
   `DLSE_ASSERT_HOLDS(a_walk_bounded, clock, reset, (state_ff == ST_WALK) |-> (pos_ff <= IDLE_SLOT))
endmodule
`default_nettype wire

>>> tb/scheduler_tb_pkg.sv
`timescale 1ns / 1ps
package scheduler_tb_pkg;
   typedef enum logic [1:0] {
      KIND_SCHEDULE = 2'd0,
      KIND_CANCEL   = 2'd1,
      KIND_SERVICE  = 2'd2,
      KIND_NOP      = 2'd3
   } kind_type;

   localparam logic [3:0]  IDLE_SLOT       = 4'd15;
   localparam logic [30:0] IDLE_PERIOD_RST = 31'h4000;
endpackage

>>> tb/delta_list_event_scheduler_checker.sv
`timescale 1ns / 1ps
module delta_list_event_scheduler_checker import scheduler_tb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_kind,
   input  logic [3:0]         req_event_id,
   input  logic [30:0]        req_delay,
   input  logic [30:0]        req_pending_cycles,
   input  logic               csr_write_enable,
   input  logic [30:0]        csr_write_data,
   input  logic               rsp_strobe,
   input  logic               rsp_fired_valid,
   input  logic [3:0]         rsp_fired_event,
   input  logic [3:0]         rsp_head_event,
   input  logic signed [31:0] rsp_countdown,
   input  logic signed [31:0] rsp_duration,
   input  logic               rsp_more_due,
   input  logic [31:0]        rsp_cycle_count,
   output int                 fail_count,
   output int                 outstanding
);
   typedef struct {
      logic        fired_valid;
      logic [3:0]  fired_event;
      logic [3:0]  head_event;
      logic [31:0] countdown;
      logic [31:0] duration;
      logic        more_due;
      logic [31:0] cycle_count;
   } status_type;

   status_type  status_q[$];
   logic [31:0] slot_delta[16];
   logic [3:0]  slot_next[16];
   logic        slot_linked[16];
   logic [3:0]  head_slot;
   logic [31:0] head_cd, head_dur, total_cycles, idle_period;

   task automatic unlink_slot(input logic [3:0] n, input logic [31:0] pend);
      logic [3:0] succ;
      logic [3:0] cur;
      bit         done;
      if (!slot_linked[n]) return;
      succ = slot_next[n];
      slot_delta[succ] += slot_delta[n];
      if (head_slot == n) begin
         head_slot = succ;
         head_dur  = slot_delta[succ];
         head_cd   = slot_delta[succ] - pend;
      end else begin
         cur  = head_slot;
         done = 0;
         for (int s = 0; s < 16; s++) begin
            if (!done) begin
               if (slot_next[cur] == n) begin
                  slot_next[cur] = succ;
                  done = 1;
               end else begin
                  cur = slot_next[cur];
               end
            end
         end
      end
      slot_linked[n] = 0;
      slot_delta[IDLE_SLOT] = idle_period;
   endtask

   task automatic insert_slot(input logic [3:0] n, input logic [31:0] dly,
                              input logic [31:0] pend);
      logic [3:0]  cur;
      logic [3:0]  prev;
      logic [31:0] running;
      bit          has_prev;
      bit          done;
      if (slot_linked[n]) unlink_slot(n, pend);
      cur      = head_slot;
      prev     = '0;
      running  = 32'd0 - pend;
      has_prev = 0;
      done     = 0;
      for (int s = 0; s <= 16; s++) begin
         if (!done) begin
            if (cur == IDLE_SLOT || $signed(running + slot_delta[cur]) > $signed(dly)) begin
               slot_next[n]    = cur;
               slot_delta[n]   = dly - running;
               slot_delta[cur] -= slot_delta[n];
               slot_linked[n]  = 1;
               if (!has_prev) begin
                  head_slot = n;
                  head_dur  = slot_delta[n];
                  head_cd   = dly;
               end else begin
                  slot_next[prev] = n;
               end
               done = 1;
            end else begin
               running += slot_delta[cur];
               prev     = cur;
               has_prev = 1;
               cur      = slot_next[cur];
            end
         end
      end
      slot_delta[IDLE_SLOT] = idle_period;
   endtask

   task automatic apply_beat(input kind_type kind, input logic [3:0] id,
                             input logic [30:0] dly, input logic [30:0] pend);
      status_type  st;
      logic [31:0] old_cd;
      logic [3:0]  popped;
      st.fired_valid = 0;
      st.fired_event = '0;
      if ((kind == KIND_SCHEDULE || kind == KIND_CANCEL) && id != IDLE_SLOT) begin
         if (kind == KIND_SCHEDULE) insert_slot(id, {1'b0, dly}, {1'b0, pend});
         else unlink_slot(id, {1'b0, pend});
      end else if (kind == KIND_SERVICE && $signed(head_cd) <= 0) begin
         old_cd = head_cd;
         popped = head_slot;
         total_cycles += head_dur;
         st.fired_valid = 1;
         st.fired_event = popped;
         if (popped == IDLE_SLOT) begin
            slot_delta[IDLE_SLOT]  = idle_period;
            slot_linked[IDLE_SLOT] = 1;
         end else begin
            head_slot = slot_next[popped];
            slot_linked[popped] = 0;
         end
         head_dur = slot_delta[head_slot];
         head_cd  = old_cd + head_dur;
      end
      st.head_event  = head_slot;
      st.countdown   = head_cd;
      st.duration    = head_dur;
      st.more_due    = $signed(head_cd) <= 0;
      st.cycle_count = total_cycles;
      status_q.push_back(st);
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %h, got %h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      status_type st;
      if (reset) begin
         idle_period = {1'b0, IDLE_PERIOD_RST};
         for (int i = 0; i < 16; i++) begin
            slot_delta[i]  = '0;
            slot_next[i]   = '0;
            slot_linked[i] = 0;
         end
         slot_delta[IDLE_SLOT]  = idle_period;
         slot_linked[IDLE_SLOT] = 1;
         head_slot    = IDLE_SLOT;
         head_cd      = '0;
         head_dur     = '0;
         total_cycles = '0;
         status_q.delete();
      end else begin
         if (csr_write_enable) idle_period = {1'b0, csr_write_data};
         // check the response before logging a beat accepted on this same edge
         if (rsp_strobe) begin
            if (status_q.size() == 0) begin
               $error("response beat with no request outstanding");
               fail_count++;
            end else begin
               st = status_q.pop_front();
               check_field("fired_valid", st.fired_valid, rsp_fired_valid);
               check_field("fired_event", st.fired_event, rsp_fired_event);
               check_field("head_event", st.head_event, rsp_head_event);
               check_field("countdown", st.countdown, rsp_countdown);
               check_field("duration", st.duration, rsp_duration);
               check_field("more_due", st.more_due, rsp_more_due);
               check_field("cycle_count", st.cycle_count, rsp_cycle_count);
            end
         end
         if (start && !busy)
            apply_beat(kind_type'(req_kind), req_event_id, req_delay, req_pending_cycles);
      end
      outstanding = status_q.size();
   end

   initial fail_count = 0;
endmodule

>>> tb/delta_list_event_scheduler_unit_tb.sv
`timescale 1ns / 1ps
module delta_list_event_scheduler_unit_tb;
   import scheduler_tb_pkg::*;

   localparam int STALL_LIMIT = 4000;

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic [1:0]         req_kind = '0;
   logic [3:0]         req_event_id = '0;
   logic [30:0]        req_delay = '0;
   logic [30:0]        req_pending_cycles = '0;
   logic               csr_write_enable = 0;
   logic [30:0]        csr_write_data = '0;
   logic               rsp_strobe, rsp_fired_valid, rsp_more_due;
   logic [3:0]         rsp_fired_event, rsp_head_event;
   logic signed [31:0] rsp_countdown, rsp_duration;
   logic [31:0]        rsp_cycle_count;
   int                 fail_count, outstanding;
   int                 idle_cycles = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   delta_list_event_scheduler_unit DUT (.*);

   delta_list_event_scheduler_checker u_checker (.*);

   // watchdog: no beat moving on either channel for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_beat(input kind_type kind, input logic [3:0] id,
                            input logic [30:0] dly, input logic [30:0] pend);
      req_kind           <= kind;
      req_event_id       <= id;
      req_delay          <= dly;
      req_pending_cycles <= pend;
      start              <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic random_gap();
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                        : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off until every expected response is back, then let the block settle
   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (outstanding != 0 || busy) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic write_idle_period(input logic [30:0] value);
      csr_write_enable <= 1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 0;
      @(posedge clock);
   endtask

   function automatic logic [30:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return 31'($urandom);
         1:       return 31'h7FFF_FFFF - 31'($urandom_range(0, 8));
         2:       return 31'($urandom_range(0, 2000));
         default: return 31'($urandom_range(0, 12));
      endcase
   endfunction

   task automatic random_phase(input int beats);
      int       sent;
      int       roll;
      kind_type kind;
      logic [3:0] id;
      sent = 0;
      while (sent < beats) begin
         roll = $urandom_range(0, 99);
         kind = roll < 45 ? KIND_SCHEDULE : roll < 60 ? KIND_CANCEL :
                roll < 96 ? KIND_SERVICE : KIND_NOP;
         id = ($urandom_range(0, 29) == 0) ? 4'($urandom_range(15, 15))
                                           : 4'($urandom_range(0, 14));
         send_beat(kind, id, pick_value(), pick_value());
         if (kind == KIND_NOP || ((kind == KIND_SCHEDULE || kind == KIND_CANCEL)
                                  && id == IDLE_SLOT))
            ; // ignored beats do not count
         else sent++;
         random_gap();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every kind, relink, head cancel, ignored slots
      send_beat(KIND_SERVICE, 4'd0, 31'd0, 31'd0);
      send_beat(KIND_SCHEDULE, 4'd0, 31'd0, 31'd0);
      send_beat(KIND_SERVICE, 4'd0, 31'd0, 31'd0);
      send_beat(KIND_SCHEDULE, 4'd14, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      send_beat(KIND_SCHEDULE, 4'd3, 31'd5, 31'd0);
      send_beat(KIND_SCHEDULE, 4'd7, 31'd9, 31'd1);
      send_beat(KIND_SCHEDULE, 4'd3, 31'd20, 31'd2);
      send_beat(KIND_SERVICE, 4'd0, 31'd0, 31'd0);
      send_beat(KIND_CANCEL, 4'd7, 31'd0, 31'd4);
      send_beat(KIND_CANCEL, 4'd5, 31'd0, 31'd0);
      send_beat(KIND_CANCEL, 4'd14, 31'd0, 31'h7FFF_FFFF);
      send_beat(KIND_SCHEDULE, IDLE_SLOT, 31'd1, 31'd0);
      send_beat(KIND_CANCEL, IDLE_SLOT, 31'd0, 31'd0);
      send_beat(KIND_NOP, 4'd2, 31'h5555_5555, 31'h2AAA_AAAA);
      send_beat(KIND_SCHEDULE, 4'd1, 31'd0, 31'd100);
      send_beat(KIND_SERVICE, 4'd0, 31'd0, 31'd0);
      send_beat(KIND_SERVICE, 4'd0, 31'd0, 31'd0);
      send_beat(KIND_SERVICE, 4'd0, 31'd0, 31'd0);
      drain();

      write_idle_period(31'd1);
      random_phase(480);
      drain();
      write_idle_period(31'h7FFF_FFFF);
      random_phase(480);
      drain();
      write_idle_period(31'($urandom_range(1, 64)));
      random_phase(480);
      drain();

      if (fail_count == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

>>> sim.f
+incdir+rtl
rtl/dlse_pkg.sv
rtl/dlse_cell.sv
rtl/delta_list_event_scheduler_unit.sv
tb/scheduler_tb_pkg.sv
tb/delta_list_event_scheduler_checker.sv
tb/delta_list_event_scheduler_unit_tb.sv
